>>> src/i2c_transfer_register_block_defines.svh
// Assertion macros used by the top-level RTL file of the I2C transfer register block.
`ifndef I2C_TRANSFER_REGISTER_BLOCK_DEFINES_SVH
`define I2C_TRANSFER_REGISTER_BLOCK_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define I2CTR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("i2ctr assertion failed");
// Check a property on every rising clock edge, reset included.
`define I2CTR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("i2ctr assertion failed");
`else
`define I2CTR_ASSERT(label, clk, rst_n, prop)
`define I2CTR_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> src/i2ctr_pkg.sv
`timescale 1ns / 1ps

package i2ctr_pkg;

  // Command codes carried in tuser
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Word register indexes
  localparam logic [3:0] IDX_CONFIG  = 4'd8;
  localparam logic [3:0] IDX_IRQ     = 4'd9;
  localparam logic [3:0] IDX_CLOCK   = 4'd10;
  localparam logic [3:0] IDX_ID      = 4'd11;
  localparam logic [3:0] IDX_ADDRESS = 4'd12;
  localparam logic [3:0] IDX_WDATA   = 4'd13;
  localparam logic [3:0] IDX_RDATA   = 4'd14;

  // Config register bits
  localparam int unsigned CFG_START8_BIT  = 0;
  localparam int unsigned CFG_START16_BIT = 1;
  localparam int unsigned CFG_STARTN_BIT  = 2;
  localparam int unsigned CFG_ACK_LSB     = 3;
  localparam int unsigned CFG_READ_BIT    = 6;
  localparam int unsigned CFG_STOPN_BIT   = 8;

  // IRQ register bits
  localparam int unsigned IRQ_STATUS_BIT = 0;
  localparam int unsigned IRQ_ENABLE_BIT = 1;

  // Countdown timing
  localparam int unsigned TICK_W   = 18;
  localparam int unsigned DIV_W    = 10;
  localparam int unsigned PERIOD_W = 6;
  localparam int unsigned PROD_W   = 17;
  localparam logic [PERIOD_W-1:0] PERIOD_SHORT = PERIOD_W'(2 + 9 * 4);
  localparam logic [PERIOD_W-1:0] PERIOD_LONG  = PERIOD_W'(2 + 9 * 5);

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 104;

  // Input word payload, last field in the lowest bits
  typedef struct packed {
    logic [31:0] bus_read_data;
    logic [3:0]  byte_enable;
    logic [31:0] write_value;
    logic [3:0]  reg_index;
  } in_data_t;

  // Result word payload, last field in the lowest bits
  typedef struct packed {
    logic [31:0] bus_write_data;
    logic [31:0] bus_address;
    logic        bus_write_strobe;
    logic        bus_read_strobe;
    logic        irq;
    logic [31:0] read_value;
  } out_item_t;

  // Register file status seen by the top level
  typedef struct packed {
    logic timer_running;
    logic irq_line;
  } regs_status_t;

endpackage

>>> src/i2ctr_regs.sv
`timescale 1ns / 1ps

module i2ctr_regs import i2ctr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         item_valid,
  input  logic [1:0]   command,
  input  in_data_t     item,
  output out_item_t    result,
  output regs_status_t status
);

  logic [31:0]       control_r, control_nxt;
  logic [31:0]       irq_reg_r, irq_reg_nxt;
  logic [31:0]       divider_r, divider_nxt;
  logic [31:0]       ident_r, ident_nxt;
  logic [31:0]       address_r, address_nxt;
  logic [31:0]       outgoing_r, outgoing_nxt;
  logic [31:0]       incoming_r, incoming_nxt;
  logic [TICK_W-1:0] remaining_r, remaining_nxt;
  logic [TICK_W-1:0] reload_r, reload_nxt;
  logic              running_r, running_nxt;
  logic              repeats_r, repeats_nxt;
  logic              irq_line_r, irq_line_nxt;

  logic [31:0]       lane_mask;
  logic [31:0]       cur_reg;
  logic [31:0]       merged;
  logic [DIV_W:0]    div_p1;
  logic [PROD_W-1:0] prod_short;
  logic [PROD_W-1:0] prod_long;
  logic [TICK_W-1:0] period_short;
  logic [TICK_W-1:0] period_long;
  logic [TICK_W-1:0] rem_dec;

  // Expand byte enables to a bit mask
  assign lane_mask = {{8{item.byte_enable[3]}}, {8{item.byte_enable[2]}},
                      {8{item.byte_enable[1]}}, {8{item.byte_enable[0]}}};

  // Select the addressed register for reads and merges
  always_comb begin
    unique case (item.reg_index)
      IDX_CONFIG:  cur_reg = control_r;
      IDX_IRQ:     cur_reg = irq_reg_r;
      IDX_CLOCK:   cur_reg = divider_r;
      IDX_ID:      cur_reg = ident_r;
      IDX_ADDRESS: cur_reg = address_r;
      IDX_WDATA:   cur_reg = outgoing_r;
      IDX_RDATA:   cur_reg = incoming_r;
      default:     cur_reg = '0;
    endcase
  end

  assign merged = (cur_reg & ~lane_mask) | (item.write_value & lane_mask);

  // Period = 4 * (div + 1) * bits, from the current clock register
  assign div_p1       = {1'b0, divider_r[DIV_W-1:0]} + (DIV_W+1)'(1);
  assign prod_short   = PROD_W'(div_p1) * PROD_W'(PERIOD_SHORT);
  assign prod_long    = PROD_W'(div_p1) * PROD_W'(PERIOD_LONG);
  assign period_short = TICK_W'({prod_short, 2'b00});
  assign period_long  = TICK_W'({prod_long, 2'b00});
  assign rem_dec      = remaining_r - TICK_W'(1);

  // Next state and result for one word
  always_comb begin
    control_nxt   = control_r;
    irq_reg_nxt   = irq_reg_r;
    divider_nxt   = divider_r;
    ident_nxt     = ident_r;
    address_nxt   = address_r;
    outgoing_nxt  = outgoing_r;
    incoming_nxt  = incoming_r;
    remaining_nxt = remaining_r;
    reload_nxt    = reload_r;
    running_nxt   = running_r;
    repeats_nxt   = repeats_r;
    irq_line_nxt  = irq_line_r;
    result        = '0;

    unique case (command)
      CMD_READ: begin
        result.read_value = cur_reg;
      end
      CMD_WRITE: begin
        unique case (item.reg_index)
          IDX_CONFIG: begin
            control_nxt = merged;
            // Start bits by priority, then stop
            priority if (merged[CFG_START8_BIT]) begin
              remaining_nxt = period_short;
              reload_nxt    = period_short;
              running_nxt   = 1'b1;
              repeats_nxt   = 1'b0;
            end else if (merged[CFG_START16_BIT]) begin
              remaining_nxt = period_long;
              reload_nxt    = period_long;
              running_nxt   = 1'b1;
              repeats_nxt   = 1'b0;
            end else if (merged[CFG_STARTN_BIT]) begin
              remaining_nxt = period_short;
              reload_nxt    = period_short;
              running_nxt   = 1'b1;
              repeats_nxt   = 1'b1;
            end else if (merged[CFG_STOPN_BIT]) begin
              running_nxt = 1'b0;
            end
          end
          IDX_IRQ: begin
            irq_reg_nxt = merged;
            // Writing one to status with lane 0 enabled clears it
            if (item.byte_enable[0] && item.write_value[IRQ_STATUS_BIT]) begin
              irq_reg_nxt[IRQ_STATUS_BIT] = 1'b0;
            end
            if (!irq_reg_nxt[IRQ_STATUS_BIT]) begin
              irq_line_nxt = 1'b0;
            end
          end
          IDX_CLOCK:   divider_nxt  = merged;
          IDX_ID:      ident_nxt    = merged;
          IDX_ADDRESS: address_nxt  = merged;
          IDX_WDATA:   outgoing_nxt = merged;
          IDX_RDATA:   incoming_nxt = merged;
          default: ;
        endcase
      end
      CMD_TICK: begin
        if (running_r) begin
          remaining_nxt = rem_dec;
          // Complete the transfer on expiry
          if (rem_dec == '0) begin
            result.bus_address = address_r;
            if (control_r[CFG_READ_BIT]) begin
              incoming_nxt           = item.bus_read_data;
              result.bus_read_strobe = 1'b1;
            end else begin
              result.bus_write_data   = outgoing_r;
              result.bus_write_strobe = 1'b1;
            end
            control_nxt[CFG_ACK_LSB +: 3] = control_r[CFG_ACK_LSB +: 3] |
                                            control_r[CFG_START8_BIT +: 3];
            if (irq_reg_r[IRQ_ENABLE_BIT]) begin
              irq_reg_nxt[IRQ_STATUS_BIT] = 1'b1;
              irq_line_nxt                = 1'b1;
            end
            if (repeats_r) begin
              remaining_nxt = reload_r;
            end else begin
              running_nxt = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase

    result.irq = irq_line_nxt;
  end

  // Commit state when a word passes through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r   <= '0;
      irq_reg_r   <= '0;
      divider_r   <= '0;
      ident_r     <= '0;
      address_r   <= '0;
      outgoing_r  <= '0;
      incoming_r  <= '0;
      remaining_r <= '0;
      reload_r    <= '0;
      running_r   <= 1'b0;
      repeats_r   <= 1'b0;
      irq_line_r  <= 1'b0;
    end else if (item_valid) begin
      control_r   <= control_nxt;
      irq_reg_r   <= irq_reg_nxt;
      divider_r   <= divider_nxt;
      ident_r     <= ident_nxt;
      address_r   <= address_nxt;
      outgoing_r  <= outgoing_nxt;
      incoming_r  <= incoming_nxt;
      remaining_r <= remaining_nxt;
      reload_r    <= reload_nxt;
      running_r   <= running_nxt;
      repeats_r   <= repeats_nxt;
      irq_line_r  <= irq_line_nxt;
    end
  end

  assign status.timer_running = running_r;
  assign status.irq_line      = irq_line_r;

endmodule

>>> src/i2c_transfer_register_block.sv
`timescale 1ns / 1ps
// An accepted word is held in the input register and registered as a result once the
// result register is free. One word per cycle while out_tready holds; the input register
// feeds the register file and result register in one pass; state updates with the result.
// Reset: rst_n low at a clock edge clears all seven registers, the countdown and the
// interrupt line, and empties both the input and the result register.
`include "i2c_transfer_register_block_defines.svh"

module i2c_transfer_register_block import i2ctr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // reg_index[3:0], write_value[35:4], byte_enable[39:36], bus_read_data[71:40]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command[1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // read_value[31:0], irq[32], bus_read_strobe[33], bus_write_strobe[34],
  // bus_address[66:35], bus_write_data[98:67], zero fill[103:99]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned OUT_PAD_W = OUT_DATA_W - $bits(out_item_t);

  logic         s1_valid_r;
  logic [1:0]   s1_cmd_r;
  in_data_t     s1_data_r;
  logic         out_valid_r;
  out_item_t    out_item_r;
  out_item_t    result;
  regs_status_t status;
  logic         in_fire;
  logic         s1_adv;
  logic         s1_fire;
  logic         out_strobe;

  // Advance the input register when the result register is free
  assign s1_adv    = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_tuser;
      s1_data_r <= in_data_t'(in_tdata);
    end
  end

  i2ctr_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_fire),
    .command    (s1_cmd_r),
    .item       (s1_data_r),
    .result     (result),
    .status     (status)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_item_r};
  assign out_strobe = out_item_r.bus_read_strobe || out_item_r.bus_write_strobe;

  // A transfer completes as either a read or a write, never both
  `I2CTR_ASSERT(a_strobe_excl, clk, rst_n, out_valid_r |-> !(out_item_r.bus_read_strobe && out_item_r.bus_write_strobe))
  // Input stalls only behind a full input register and a stalled result
  `I2CTR_ASSERT(a_stall_cause, clk, rst_n, !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
  // A processed word always lands in the result register
  `I2CTR_ASSERT(a_fire_lands, clk, rst_n, s1_fire |=> out_valid_r)
  // The reported interrupt level matches the committed line
  `I2CTR_ASSERT(a_irq_match, clk, rst_n, s1_fire |=> (out_item_r.irq == status.irq_line))
  // No transfer completes while the countdown is stopped
  `I2CTR_ASSERT(a_idle_no_strobe, clk, rst_n, s1_fire && !status.timer_running |=> !out_strobe)

endmodule
